// File: hw/rtl/fal_pkg.sv
// Shared field widths, operation and status codes, and control structs of the allocator.
package fal_pkg;

  // Transaction field widths
  localparam int OpWidth    = 2;
  localparam int IndexWidth = 10;
  localparam int CountWidth = 11;

  // Reset value of the pool size register
  localparam logic [CountWidth-1:0] PoolSizeReset = 11'd1024;

  // Operation codes
  localparam logic [OpWidth-1:0] OP_CLEAR = 2'd0;
  localparam logic [OpWidth-1:0] OP_ALLOC = 2'd1;
  localparam logic [OpWidth-1:0] OP_FREE  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_OOM          = 2'd1;
  localparam logic [1:0] ST_RANGE        = 2'd2;
  localparam logic [1:0] ST_ALREADY_FREE = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // request transaction taken this cycle
    logic clr_step;  // write one pool entry of the clear walk
    logic eval;      // read data is back, finish allocate or free
    logic out_load;  // load the response register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_clear;    // incoming request is a clear
    logic needs_eval;  // incoming request needs a pool entry read
    logic clr_empty;   // clear with a pool size of zero
    logic clr_last;    // clear walk at its last entry
    logic out_busy;    // response register full and not taken
  } sts_t;

endpackage

// File: hw/rtl/fal_req_if.sv
// Request channel: operation and entry index with valid/ready handshake.
interface fal_req_if;
  logic                           valid;
  logic                           ready;
  logic [fal_pkg::OpWidth-1:0]    op;
  logic [fal_pkg::IndexWidth-1:0] entry_index;

  modport source (output valid, op, entry_index, input ready);
  modport sink   (input valid, op, entry_index, output ready);
endinterface

// File: hw/rtl/fal_rsp_if.sv
// Response channel: status, allocated index and free counts with valid/ready handshake.
interface fal_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [fal_pkg::IndexWidth-1:0] alloc_index;
  logic [fal_pkg::CountWidth-1:0] free_count;
  logic [fal_pkg::CountWidth-1:0] low_free_count;

  modport source (output valid, status, alloc_index, free_count, low_free_count, input ready);
  modport sink   (input valid, status, alloc_index, free_count, low_free_count, output ready);
endinterface

// File: hw/rtl/fal_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/fal_ctrl.sv
// Controller state machine: sequences clear walk, read-modify-write and response handoff.
module fal_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fal_pkg::sts_t sts_i,
  output fal_pkg::cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLEAR = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and command decode
  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.accept    = accept;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (sts_i.is_clear && !sts_i.clr_empty) begin
            state_d = S_CLEAR;
          end else if (sts_i.needs_eval) begin
            state_d = S_EVAL;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_DONE;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Never overwrite a response that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !sts_i.out_busy)
    else $error("response register overwritten while full");

  // Evaluation is always followed by idle or done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |=> (state_q == S_IDLE) || (state_q == S_DONE))
    else $error("evaluation did not finish in one cycle");

endmodule

// File: hw/rtl/fal_dp.sv
// Datapath: pool RAM, list head, free counters, clear walk counter and response register.
module fal_dp #(
  parameter int POOL_DEPTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fal_pkg::CountWidth-1:0] cfg_wdata_i,
  input  logic [fal_pkg::OpWidth-1:0]    op_i,
  input  logic [fal_pkg::IndexWidth-1:0] entry_index_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [1:0]                     status_o,
  output logic [fal_pkg::IndexWidth-1:0] alloc_index_o,
  output logic [fal_pkg::CountWidth-1:0] free_count_o,
  output logic [fal_pkg::CountWidth-1:0] low_free_count_o,
  input  fal_pkg::cmd_t                  cmd_i,
  output fal_pkg::sts_t                  sts_o
);

  localparam int          IW     = $clog2(POOL_DEPTH);
  localparam int          CW     = $clog2(POOL_DEPTH + 1);
  localparam logic [31:0] DepthW = 32'(POOL_DEPTH);

  // Control state
  logic [fal_pkg::CountWidth-1:0] pool_size_q;
  logic [CW-1:0]                  applied_q;
  logic [CW-1:0]                  total_q, total_d;
  logic [CW-1:0]                  low_q, low_d;
  logic [IW-1:0]                  head_q, head_d;
  logic [CW-1:0]                  cnt_q;
  logic                           out_valid_q;

  // Request and result payload
  logic [fal_pkg::OpWidth-1:0]    op_q;
  logic [IW-1:0]                  idx_q;
  logic [1:0]                     status_q, status_d;
  logic [IW-1:0]                  got_q, got_d;
  logic [1:0]                     out_status_q;
  logic [IW-1:0]                  out_got_q;
  logic [CW-1:0]                  out_total_q;
  logic [CW-1:0]                  out_low_q;

  // RAM port signals: entry word is {free mark, next link}
  logic                           ram_we;
  logic [IW-1:0]                  ram_waddr;
  logic [IW:0]                    ram_wdata;
  logic                           ram_re;
  logic [IW-1:0]                  ram_raddr;
  logic [IW:0]                    ram_rdata;
  logic                           rd_mark;
  logic [IW-1:0]                  rd_next;

  logic [CW-1:0]                  size_sat;
  logic                           in_range;
  logic [CW-1:0]                  cnt_plus;
  logic                           clr_last;
  logic                           alloc_ok;
  logic                           free_ok;

  // Saturate the requested pool size to the depth
  assign size_sat = (32'(pool_size_q) > DepthW) ? CW'(POOL_DEPTH) : CW'(pool_size_q);
  assign in_range = 32'(entry_index_i) < 32'(applied_q);
  assign cnt_plus = cnt_q + CW'(1);
  assign clr_last = (cnt_plus == applied_q);

  assign rd_mark = ram_rdata[IW];
  assign rd_next = ram_rdata[IW-1:0];

  // Report request kind and progress to the controller
  always_comb begin
    sts_o            = '0;
    sts_o.is_clear   = (op_i == fal_pkg::OP_CLEAR);
    sts_o.needs_eval = (op_i == fal_pkg::OP_ALLOC) || ((op_i == fal_pkg::OP_FREE) && in_range);
    sts_o.clr_empty  = (size_sat == '0);
    sts_o.clr_last   = clr_last;
    sts_o.out_busy   = out_valid_q && !out_ready_i;
  end

  // Read the head entry for allocate, the named entry for free
  assign ram_re    = cmd_i.accept && sts_o.needs_eval;
  assign ram_raddr = (op_i == fal_pkg::OP_ALLOC) ? head_q : IW'(entry_index_i);

  // Finish allocate or free from the entry just read
  assign alloc_ok = (total_q != '0) && rd_mark;
  assign free_ok  = !rd_mark;

  always_comb begin
    status_d  = fal_pkg::ST_OK;
    got_d     = '0;
    total_d   = total_q;
    low_d     = low_q;
    head_d    = head_q;
    ram_we    = 1'b0;
    ram_waddr = head_q;
    ram_wdata = {1'b0, rd_next};
    if (cmd_i.clr_step) begin
      // Chain entry to its successor, the last one links to zero
      ram_we    = 1'b1;
      ram_waddr = cnt_q[IW-1:0];
      ram_wdata = {1'b1, (clr_last ? IW'(0) : cnt_plus[IW-1:0])};
    end else if (cmd_i.eval) begin
      if (op_q == fal_pkg::OP_ALLOC) begin
        if (alloc_ok) begin
          ram_we  = 1'b1;
          got_d   = head_q;
          total_d = total_q - CW'(1);
          low_d   = (total_d < low_q) ? total_d : low_q;
          head_d  = (32'(rd_next) < DepthW) ? rd_next : '0;
        end else begin
          status_d = fal_pkg::ST_OOM;
        end
      end else begin
        ram_waddr = idx_q;
        ram_wdata = {1'b1, head_q};
        if (free_ok) begin
          ram_we  = 1'b1;
          total_d = total_q + CW'(1);
          head_d  = idx_q;
        end else begin
          status_d = fal_pkg::ST_ALREADY_FREE;
        end
      end
    end
  end

  fal_ram #(
    .WIDTH (IW + 1),
    .DEPTH (POOL_DEPTH)
  ) u_pool_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Hold configuration, list head, counters and response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= fal_pkg::PoolSizeReset;
      applied_q   <= '0;
      total_q     <= '0;
      low_q       <= '0;
      head_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pool_size_q <= cfg_wdata_i;
      end
      if (cmd_i.accept && sts_o.is_clear) begin
        applied_q <= size_sat;
        total_q   <= size_sat;
        low_q     <= size_sat;
        head_q    <= '0;
        cnt_q     <= '0;
      end else if (cmd_i.clr_step) begin
        cnt_q <= cnt_plus;
      end else if (cmd_i.eval) begin
        total_q <= total_d;
        low_q   <= low_d;
        head_q  <= head_d;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture request, then result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= op_i;
      idx_q    <= IW'(entry_index_i);
      got_q    <= '0;
      status_q <= ((op_i == fal_pkg::OP_FREE) && !in_range) ? fal_pkg::ST_RANGE
                                                            : fal_pkg::ST_OK;
    end else if (cmd_i.eval) begin
      status_q <= status_d;
      got_q    <= got_d;
    end
    if (cmd_i.out_load) begin
      if (cmd_i.eval) begin
        out_status_q <= status_d;
        out_got_q    <= got_d;
        out_total_q  <= total_d;
        out_low_q    <= low_d;
      end else begin
        out_status_q <= status_q;
        out_got_q    <= got_q;
        out_total_q  <= total_q;
        out_low_q    <= low_q;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign alloc_index_o    = fal_pkg::IndexWidth'(out_got_q);
  assign free_count_o     = fal_pkg::CountWidth'(out_total_q);
  assign low_free_count_o = fal_pkg::CountWidth'(out_low_q);

  // Free count never exceeds the applied pool size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= applied_q)
    else $error("free count above pool size");

  // Low-water mark never above the current free count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_q <= total_q)
    else $error("low-water mark above free count");

endmodule

// File: hw/rtl/free_list_entry_allocator.sv
// Allocate and free accept the request, then do one RAM read-modify-write step on the
// registered RAM read data; one transaction is in flight at a time.
// Clear walks the pool RAM, writing one entry per cycle.
// Out-of-range frees and unknown operations skip the RAM. A waiting response does not
// block the next request; a result waits in place until the response register frees.
// Reset: counts, head and applied size zero, pool size 1024; pool RAM is left as is.
module free_list_entry_allocator #(
  parameter int POOL_DEPTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fal_pkg::CountWidth-1:0] cfg_wdata_i,
  fal_req_if.sink                        req_i,
  fal_rsp_if.source                      rsp_o
);

  fal_pkg::cmd_t cmd;
  fal_pkg::sts_t sts;

  fal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fal_dp #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .op_i             (req_i.op),
    .entry_index_i    (req_i.entry_index),
    .out_ready_i      (rsp_o.ready),
    .out_valid_o      (rsp_o.valid),
    .status_o         (rsp_o.status),
    .alloc_index_o    (rsp_o.alloc_index),
    .free_count_o     (rsp_o.free_count),
    .low_free_count_o (rsp_o.low_free_count),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

endmodule

// File: bench/tb_free_list_entry_allocator.sv
// Self-checking bench for the free-list entry allocator: directed and random transactions.
`timescale 1ns / 1ps

module tb_free_list_entry_allocator;
  import fal_pkg::*;

  localparam int PoolDepth = 1024;
  localparam int CycleLimit = 400000;
  localparam int MaxReports = 10;
  localparam logic [OpWidth-1:0] OpUnknown = 2'd3;

  typedef struct packed {
    logic [OpWidth-1:0]    op;
    logic [IndexWidth-1:0] entry_index;
  } pool_req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [IndexWidth-1:0] alloc_index;
    logic [CountWidth-1:0] free_count;
    logic [CountWidth-1:0] low_free_count;
  } pool_rsp_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CountWidth-1:0] cfg_wdata;

  fal_req_if req_if ();
  fal_rsp_if rsp_if ();

  free_list_entry_allocator #(
    .POOL_DEPTH(PoolDepth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Shadow copy of the pool
  bit                    shadow_mark [PoolDepth];
  logic [IndexWidth-1:0] shadow_link [PoolDepth];
  logic [IndexWidth-1:0] shadow_head;
  logic [CountWidth-1:0] shadow_total;
  logic [CountWidth-1:0] shadow_low;
  logic [CountWidth-1:0] shadow_applied;
  logic [CountWidth-1:0] shadow_pool_size;

  pool_req_t req_backlog_q[$];
  pool_rsp_t rsp_expected_q[$];

  bit idle_on;
  int cycle_count;
  int error_count;
  int req_accepted;
  int rsp_checked;
  int status_seen [4];
  int clears_seen;

  // Clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Apply one transaction to the shadow pool and return the response it should give
  function automatic pool_rsp_t predict_pool_response(pool_req_t r);
    pool_rsp_t p;
    int unsigned n;
    p = '0;
    p.status = ST_OK;
    case (r.op)
      OP_CLEAR: begin
        n = (shadow_pool_size > PoolDepth) ? PoolDepth : shadow_pool_size;
        for (int i = 0; i < n; i++) begin
          shadow_mark[i] = 1'b1;
          shadow_link[i] = (i + 1 < n) ? IndexWidth'(i + 1) : '0;
        end
        shadow_applied = CountWidth'(n);
        shadow_head = '0;
        shadow_total = CountWidth'(n);
        shadow_low = CountWidth'(n);
        clears_seen++;
      end
      OP_ALLOC: begin
        if (shadow_total == 0 || !shadow_mark[shadow_head]) begin
          p.status = ST_OOM;
        end else begin
          p.alloc_index = shadow_head;
          shadow_mark[shadow_head] = 1'b0;
          shadow_head = shadow_link[shadow_head];
          shadow_total = shadow_total - 1'b1;
          if (shadow_total < shadow_low) shadow_low = shadow_total;
        end
      end
      OP_FREE: begin
        if (r.entry_index >= shadow_applied) begin
          p.status = ST_RANGE;
        end else if (shadow_mark[r.entry_index]) begin
          p.status = ST_ALREADY_FREE;
        end else begin
          shadow_mark[r.entry_index] = 1'b1;
          shadow_link[r.entry_index] = shadow_head;
          shadow_head = r.entry_index;
          shadow_total = shadow_total + 1'b1;
        end
      end
      default: ;
    endcase
    p.free_count = shadow_total;
    p.low_free_count = shadow_low;
    return p;
  endfunction

  function automatic bit take_break();
    return idle_on && ($urandom_range(99) < 22);
  endfunction

  // Request driver: hold a transaction until taken, then present the next one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        rsp_expected_q.push_back(predict_pool_response({req_if.op, req_if.entry_index}));
        req_accepted++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (req_backlog_q.size() != 0 && !take_break()) begin
          pool_req_t r;
          r = req_backlog_q.pop_front();
          req_if.valid <= 1'b1;
          req_if.op <= r.op;
          req_if.entry_index <= r.entry_index;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: check each transaction against the oldest expectation
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        pool_rsp_t got;
        pool_rsp_t want;
        got = {rsp_if.status, rsp_if.alloc_index, rsp_if.free_count, rsp_if.low_free_count};
        if (rsp_expected_q.size() == 0) begin
          error_count++;
          if (error_count <= MaxReports)
            $display("ERROR: unexpected response status=%0d idx=%0d count=%0d low=%0d",
                     got.status, got.alloc_index, got.free_count, got.low_free_count);
        end else begin
          want = rsp_expected_q.pop_front();
          rsp_checked++;
          status_seen[want.status]++;
          if (got.status !== want.status || got.alloc_index !== want.alloc_index ||
              got.free_count !== want.free_count ||
              got.low_free_count !== want.low_free_count) begin
            error_count++;
            if (error_count <= MaxReports)
              $display({"ERROR: response %0d: exp status=%0d idx=%0d count=%0d low=%0d, ",
                        "got status=%0d idx=%0d count=%0d low=%0d"}, rsp_checked,
                       want.status, want.alloc_index, want.free_count, want.low_free_count,
                       got.status, got.alloc_index, got.free_count, got.low_free_count);
          end
        end
      end
      rsp_if.ready <= !take_break();
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("ERROR: timeout after %0d cycles", cycle_count);
      $display("tb_free_list_entry_allocator: done, errors");
      $finish;
    end
  end

  task automatic queue_req(input logic [OpWidth-1:0] op, input logic [IndexWidth-1:0] idx);
    req_backlog_q.push_back('{op: op, entry_index: idx});
  endtask

  // Wait until every transaction has been answered, then let the block settle
  task automatic settle();
    while (req_backlog_q.size() != 0 || req_if.valid || rsp_expected_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_pool_size(input logic [CountWidth-1:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    shadow_pool_size = value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Random phase: bursts leaning to allocate or to free, mostly on in-pool indexes
  task automatic queue_random_phase(input logic [CountWidth-1:0] size, input int count);
    int unsigned span;
    int unsigned alloc_pct;
    int unsigned pick;
    logic [OpWidth-1:0]    op;
    logic [IndexWidth-1:0] idx;
    span = (size > PoolDepth) ? PoolDepth : size;
    alloc_pct = 50;
    for (int k = 0; k < count; k++) begin
      if (k % 10 == 0) alloc_pct = $urandom_range(1) ? 70 : 30;
      idx = IndexWidth'($urandom_range(PoolDepth - 1));
      pick = $urandom_range(99);
      if (pick < 3) begin
        op = OP_CLEAR;
      end else if (pick < 6) begin
        op = OpUnknown;
      end else begin
        op = ($urandom_range(99) < alloc_pct) ? OP_ALLOC : OP_FREE;
        if (op == OP_FREE && span > 0 && $urandom_range(99) < 85)
          idx = IndexWidth'($urandom_range(span - 1));
      end
      queue_req(op, idx);
    end
  endtask

  initial begin
    logic [CountWidth-1:0] size;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.op = OP_CLEAR;
    req_if.entry_index = '0;
    rsp_if.ready = 1'b0;
    idle_on = 1'b1;
    shadow_head = '0;
    shadow_total = '0;
    shadow_low = '0;
    shadow_applied = '0;
    shadow_pool_size = PoolSizeReset;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Before any clear: empty pool, every free out of range; then the reset size
    queue_req(OP_ALLOC, '0);
    queue_req(OP_FREE, 10'd1023);
    queue_req(OpUnknown, 10'd1023);
    queue_req(OP_CLEAR, 10'd1023);
    queue_req(OP_ALLOC, '0);
    queue_req(OP_ALLOC, 10'd1023);
    queue_req(OP_FREE, 10'd1);
    queue_req(OP_FREE, 10'd1);
    queue_req(OP_ALLOC, '0);
    settle();

    // Zero size: allocate on empty, any free out of range
    write_pool_size('0);
    queue_req(OP_CLEAR, '0);
    queue_req(OP_ALLOC, '0);
    queue_req(OP_FREE, '0);
    settle();

    // Size above depth saturates
    write_pool_size(11'd2047);
    queue_req(OP_CLEAR, '0);
    queue_req(OP_ALLOC, '0);
    queue_req(OP_FREE, '0);
    settle();

    // New size without clear: frees still checked against the applied size
    write_pool_size(11'd3);
    queue_req(OP_FREE, 10'd1000);
    queue_req(OP_CLEAR, '0);
    queue_req(OP_ALLOC, '0);
    queue_req(OP_ALLOC, '0);
    queue_req(OP_ALLOC, '0);
    queue_req(OP_ALLOC, '0);
    queue_req(OP_FREE, 10'd3);
    queue_req(OP_FREE, 10'd2);
    settle();

    // Random phases over small pools, with the extremes mixed in
    for (int ph = 0; ph < 11; ph++) begin
      case (ph)
        0:       size = '0;
        1:       size = 11'd1;
        2:       size = 11'd2;
        7:       size = 11'd1024;
        9:       size = 11'd2047;
        default: size = CountWidth'($urandom_range(3, 40));
      endcase
      idle_on = (ph != 4);
      write_pool_size(size);
      queue_req(OP_CLEAR, IndexWidth'($urandom_range(PoolDepth - 1)));
      queue_random_phase(size, 50);
      settle();
    end
    idle_on = 1'b1;
    repeat (16) @(posedge clk_i);
    error_count += rsp_expected_q.size();

    $display("Covered %0d transactions in %0d cycles, %0d clears, pool sizes from 0 to 2047.",
             req_accepted, cycle_count, clears_seen);
    $display("Responses: %0d ok, %0d out of memory, %0d out of range, %0d already free.",
             status_seen[ST_OK], status_seen[ST_OOM], status_seen[ST_RANGE],
             status_seen[ST_ALREADY_FREE]);
    if (error_count == 0) begin
      $display("tb_free_list_entry_allocator: done, clean");
    end else begin
      $display("tb_free_list_entry_allocator: done, errors");
    end
    $finish;
  end

endmodule
